### design/e2q_pkg.sv
// e2q_pkg: shared constants and types for the euler_to_quaternion block
// cordic arctangent table, gain and angle limits in q.30; no dependencies
package e2q_pkg;

  localparam int unsigned AtanEntries = 24;
  localparam int unsigned Qw = 34;  // cordic datapath width (q.30 with headroom)

  localparam logic signed [Qw-1:0] GainQ30    = 34'sd652032874;
  localparam logic signed [Qw-1:0] PiQ30      = 34'sd3373259426;
  localparam logic signed [Qw-1:0] HalfPiQ30  = 34'sd1686629713;

  typedef logic signed [Qw-1:0] cq_t;

  typedef struct packed {
    cq_t  x;
    cq_t  y;
    cq_t  z;
    logic flip;
  } cordic_lane_t;

  function automatic cq_t atan_q30(input logic [4:0] idx);
    cq_t v;
    unique case (idx)
      5'd0:  v = 34'sh03243F6A8;
      5'd1:  v = 34'sh01DAC6705;
      5'd2:  v = 34'sh00FADBAFC;
      5'd3:  v = 34'sh007F56EA6;
      5'd4:  v = 34'sh003FEAB76;
      5'd5:  v = 34'sh001FFD55B;
      5'd6:  v = 34'sh000FFFAAA;
      5'd7:  v = 34'sh0007FFF55;
      5'd8:  v = 34'sh0003FFFEA;
      5'd9:  v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/e2q_cordic_cell.sv
// e2q_cordic_cell: one rotation-mode cordic iteration for the three angle lanes
// depends on e2q_pkg
module e2q_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  e2q_pkg::cordic_lane_t   lane_in  [3],
  output e2q_pkg::cordic_lane_t   lane_out [3]
);
  import e2q_pkg::*;

  localparam logic [4:0] Idx = 5'(STAGE);

  cordic_lane_t lane_nxt [3];
  cordic_lane_t lane_r   [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_nxt[k].flip = lane_in[k].flip;
      if (!lane_in[k].z[Qw-1]) begin
        lane_nxt[k].x = lane_in[k].x - (lane_in[k].y >>> STAGE);
        lane_nxt[k].y = lane_in[k].y + (lane_in[k].x >>> STAGE);
        lane_nxt[k].z = lane_in[k].z - atan_q30(Idx);
      end else begin
        lane_nxt[k].x = lane_in[k].x + (lane_in[k].y >>> STAGE);
        lane_nxt[k].y = lane_in[k].y - (lane_in[k].x >>> STAGE);
        lane_nxt[k].z = lane_in[k].z + atan_q30(Idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;
endmodule

### design/e2q_combine.sv
// e2q_combine: triple products and q.15 rounding with saturation
// depends on e2q_pkg; three register stages, all enabled by en
module e2q_combine (
  input  logic              clk,
  input  logic              en,
  input  e2q_pkg::cq_t      cr, sr, cp, sp, cy, sy,
  output logic [63:0]       quat
);
  import e2q_pkg::*;

  // stage 1: pair products rounded to q.30
  logic signed [31:0] srcp_r, crsp_r, crcp_r, srsp_r;
  logic signed [31:0] cy1_r, sy1_r;
  // stage 2: triple products in q.60
  logic signed [63:0] t_r [8];
  // stage 3: combined, rounded, saturated
  logic [63:0] quat_r;

  function automatic logic signed [31:0] pair(input cq_t a, input cq_t b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return 32'(p >>> 30);
  endfunction

  function automatic logic [15:0] q15(input logic signed [64:0] v);
    logic signed [64:0] r;
    r = (v + 65'sd17592186044416) >>> 45;
    if (r > 65'sd32767) return 16'h7FFF;
    if (r < -65'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      srcp_r <= pair(sr, cp);
      crsp_r <= pair(cr, sp);
      crcp_r <= pair(cr, cp);
      srsp_r <= pair(sr, sp);
      cy1_r  <= 32'(cy);
      sy1_r  <= 32'(sy);
      t_r[0] <= srcp_r * cy1_r;
      t_r[1] <= crsp_r * sy1_r;
      t_r[2] <= crsp_r * cy1_r;
      t_r[3] <= srcp_r * sy1_r;
      t_r[4] <= crcp_r * sy1_r;
      t_r[5] <= srsp_r * cy1_r;
      t_r[6] <= crcp_r * cy1_r;
      t_r[7] <= srsp_r * sy1_r;
      quat_r <= {q15(65'(t_r[6]) + 65'(t_r[7])),
                 q15(65'(t_r[4]) - 65'(t_r[5])),
                 q15(65'(t_r[2]) + 65'(t_r[3])),
                 q15(65'(t_r[0]) - 65'(t_r[1]))};
    end
  end

  assign quat = quat_r;
endmodule

### design/euler_to_quaternion.sv
// euler_to_quaternion: roll/pitch/yaw to unit quaternion, top level
// depends on e2q_pkg, e2q_cordic_cell and e2q_combine
//
// usage
//  in channel: one transfer carries roll, pitch and yaw in signed q3.13 radians
//  out channel: one transfer per input carrying x, y, z, w in signed q1.15
//  pipeline: range reduction register, one cordic cell per stage
//    (min(CORDIC_STAGES,24) cells), sign fix register, then three
//    registers of product and rounding logic, then the output register
//  throughput: one transfer per cycle unless stalled; each cordic cell rotates all three
//    angles at once, so the chain takes a new item every cycle that it advances
//  stall: the whole pipeline advances only when the output register is
//    empty or being taken; in_tready follows that, so nothing is lost
//  reset: clears all valid bits; payload registers are not reset
module euler_to_quaternion #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_x, quat_y, quat_z, quat_w
);
  import e2q_pkg::*;

  localparam int unsigned Ns = (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;
  localparam int unsigned Depth = Ns + 6;  // stages holding a valid bit

  logic en;
  logic [Depth-1:0] vld_r, vld_nxt;

  // the pipeline moves as one; it moves when the last stage is free or drained
  assign en        = !vld_r[Depth-1] || out_tready;
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[Depth-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // range reduction of the half angles (raw angle << 16 is the half angle in q.30)
  cordic_lane_t lane_nxt [3];
  cordic_lane_t chain [Ns+1][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cq_t z;
      z = cq_t'($signed(in_tdata[16*k +: 16])) <<< 16;
      lane_nxt[k].x = GainQ30;
      lane_nxt[k].y = '0;
      if (z > HalfPiQ30) begin
        lane_nxt[k].z = z - PiQ30;
        lane_nxt[k].flip = 1'b1;
      end else if (z < -HalfPiQ30) begin
        lane_nxt[k].z = z + PiQ30;
        lane_nxt[k].flip = 1'b1;
      end else begin
        lane_nxt[k].z = z;
        lane_nxt[k].flip = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= lane_nxt;
    end
  end

  // chain of cordic cells, one iteration each
  for (genvar g = 0; g < Ns; g++) begin : g_cell
    e2q_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .en       (en),
      .lane_in  (chain[g]),
      .lane_out (chain[g+1])
    );
  end

  // undo the range reduction
  cq_t cos_r [3];
  cq_t sin_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cos_r[k] <= chain[Ns][k].flip ? -chain[Ns][k].x : chain[Ns][k].x;
        sin_r[k] <= chain[Ns][k].flip ? -chain[Ns][k].y : chain[Ns][k].y;
      end
    end
  end

  logic [63:0] quat;
  e2q_combine u_comb (
    .clk  (clk),
    .en   (en),
    .cr   (cos_r[0]), .sr (sin_r[0]),
    .cp   (cos_r[1]), .sp (sin_r[1]),
    .cy   (cos_r[2]), .sy (sin_r[2]),
    .quat (quat)
  );

  // output register
  logic [63:0] out_data_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= quat;
    end
  end

  assign out_tvalid = vld_r[Depth-1];
  assign out_tdata  = out_data_r;
endmodule
